### src/tahoe_pkg.sv
// Shared types, codes and reset constants of the TCP Tahoe congestion window block.
// No dependencies; every other file takes names from here by scope.
package tahoe_pkg;

    localparam int WIN_W  = 32;
    localparam int MSS_W  = 16;
    localparam int PEER_W = 30;
    localparam int DUP_W  = 8;
    localparam int CMD_W  = 2;
    localparam int RTX_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // event codes
    localparam logic [CMD_W-1:0] CMD_NEW_ACK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DUP_ACK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd3;

    // retransmit request codes
    localparam logic [RTX_W-1:0] RTX_NONE    = 2'd0;
    localparam logic [RTX_W-1:0] RTX_TIMEOUT = 2'd1;
    localparam logic [RTX_W-1:0] RTX_FAST    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MSS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_THR  = 2'd3;

    // reset values
    localparam logic [MSS_W-1:0] MSS_RST      = 16'd536;
    localparam logic [WIN_W-1:0] INIT_WIN_RST = 32'd536;
    localparam logic [WIN_W-1:0] INIT_THR_RST = 32'd65535;
    localparam logic [DUP_W-1:0] DUP_THR_RST  = 8'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PEER_W-1:0] peer_window;
        logic [DUP_W-1:0]  dup_count;
        logic              aborted;
    } in_word_t;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] threshold;
        logic [RTX_W-1:0] retransmit;
        logic             try_send;
        logic             after_timeout;
    } out_word_t;

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // saturating 32-bit add
    function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                                 input logic [WIN_W-1:0] b);
        logic [WIN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIN_W] ? {WIN_W{1'b1}} : s[WIN_W-1:0];
    endfunction

endpackage

### src/tahoe_in_if.sv
// Input channel: valid/ready handshake carrying one event word.
// Depends on tahoe_pkg for the payload type.
interface tahoe_in_if;
    logic                 valid;
    logic                 ready;
    tahoe_pkg::in_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/tahoe_out_if.sv
// Output channel: valid/ready handshake carrying one result word.
// Depends on tahoe_pkg for the payload type.
interface tahoe_out_if;
    logic                 valid;
    logic                 ready;
    tahoe_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/tcp_tahoe_congestion_window.sv
// TCP Tahoe congestion window: cwnd/ssthresh update per event word.
// New-data ACK in congestion avoidance runs the serial divide and add steps, then the final step;
// other events go straight to the final step. A new word is taken only once back in idle.
// Result register lets the next word in while an earlier result waits to be taken.
// Reset (async, active low): configuration registers to defaults, cwnd 536, ssthresh 65535, mark clear.
// Depends on tahoe_pkg, tahoe_in_if, tahoe_out_if and tahoe_div.
module tcp_tahoe_congestion_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tahoe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tahoe_pkg::CFG_DATA_W-1:0] cfg_data,
    tahoe_in_if.sink                        in_word,
    tahoe_out_if.source                     out_word
);

    localparam int W = tahoe_pkg::WIN_W;

    // sequencer, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t st_reg, st_next;

    // configuration registers
    logic [tahoe_pkg::MSS_W-1:0] mss_reg;
    logic [W-1:0]                init_win_reg;
    logic [W-1:0]                init_thr_reg;
    logic [tahoe_pkg::DUP_W-1:0] dup_thr_reg;

    // connection state
    logic [W-1:0] cwnd_reg, cwnd_next;
    logic [W-1:0] ssth_reg, ssth_next;
    logic         rto_reg, rto_next;

    // per-word flags held until the result is written
    logic [tahoe_pkg::RTX_W-1:0] rtx_reg, rtx_next;
    logic                        try_reg, try_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    tahoe_pkg::out_word_t  out_data_reg, out_data_next;

    // shared adder, divider
    logic [W-1:0]          add_b;
    logic [W-1:0]          add_sum;
    tahoe_pkg::div_ctrl_t  div_ctrl;
    tahoe_pkg::div_stat_t  div_stat;
    logic [W-1:0]          div_dividend;
    logic [W-1:0]          div_divisor;
    logic [W-1:0]          div_quo;
    logic [W-1:0]          incr;

    // loss path
    logic [W-1:0]          peer_ext;
    logic [W-1:0]          flight;
    logic [W-1:0]          half;
    logic [W-1:0]          floor2;
    logic [W-1:0]          loss_ssth;

    logic                  accept;
    logic                  slot_free;

    assign accept    = in_word.valid && in_word.ready;
    assign slot_free = !out_valid_reg || out_word.ready;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_reg      <= tahoe_pkg::MSS_RST;
            init_win_reg <= tahoe_pkg::INIT_WIN_RST;
            init_thr_reg <= tahoe_pkg::INIT_THR_RST;
            dup_thr_reg  <= tahoe_pkg::DUP_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tahoe_pkg::CFG_MSS:      mss_reg      <= cfg_data[tahoe_pkg::MSS_W-1:0];
                tahoe_pkg::CFG_INIT_WIN: init_win_reg <= cfg_data[W-1:0];
                tahoe_pkg::CFG_INIT_THR: init_thr_reg <= cfg_data[W-1:0];
                tahoe_pkg::CFG_DUP_THR:  dup_thr_reg  <= cfg_data[tahoe_pkg::DUP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // ssthresh on loss: max(min(cwnd, peer) / 2, 2 * mss)
    // ---------------------------------------------------------------
    always_comb
    begin
        peer_ext  = W'(in_word.data.peer_window);
        flight    = (cwnd_reg < peer_ext) ? cwnd_reg : peer_ext;
        half      = flight >> 1;
        floor2    = W'({mss_reg, 1'b0});
        loss_ssth = (half > floor2) ? half : floor2;
    end

    // ---------------------------------------------------------------
    // shared saturating adder: mss in slow start, increment in avoidance
    // ---------------------------------------------------------------
    assign incr    = (div_quo == '0) ? W'(1) : div_quo;
    assign add_b   = (st_reg == ST_ADD) ? incr : W'(mss_reg);
    assign add_sum = tahoe_pkg::sat_add(cwnd_reg, add_b);

    // divider gets mss*mss straight from the multiplier and registers it;
    // a zero window divides by one
    assign div_dividend = {{(W - tahoe_pkg::MSS_W){1'b0}}, mss_reg}
                        * {{(W - tahoe_pkg::MSS_W){1'b0}}, mss_reg};
    assign div_divisor  = (cwnd_reg == '0) ? W'(1) : cwnd_reg;

    tahoe_div #(
        .WIDTH (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        st_next        = st_reg;
        cwnd_next      = cwnd_reg;
        ssth_next      = ssth_reg;
        rto_next       = rto_reg;
        rtx_next       = rtx_reg;
        try_next       = try_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_ctrl.start = 1'b0;
        in_word.ready  = (st_reg == ST_IDLE);

        if (out_valid_reg && out_word.ready)
            out_valid_next = 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rtx_next = tahoe_pkg::RTX_NONE;
                    try_next = 1'b0;
                    st_next  = ST_FIN;
                    case (in_word.data.command)
                        tahoe_pkg::CMD_NEW_ACK:
                        begin
                            try_next = 1'b1;
                            if (cwnd_reg < ssth_reg)
                                cwnd_next = add_sum;
                            else
                            begin
                                div_ctrl.start = 1'b1;
                                st_next        = ST_DIV;
                            end
                        end
                        tahoe_pkg::CMD_DUP_ACK:
                        begin
                            if (in_word.data.dup_count == dup_thr_reg)
                            begin
                                ssth_next = loss_ssth;
                                cwnd_next = W'(mss_reg);
                                rtx_next  = tahoe_pkg::RTX_FAST;
                            end
                        end
                        tahoe_pkg::CMD_TIMEOUT:
                        begin
                            if (!in_word.data.aborted)
                            begin
                                ssth_next = loss_ssth;
                                cwnd_next = W'(mss_reg);
                                rto_next  = 1'b1;
                                rtx_next  = tahoe_pkg::RTX_TIMEOUT;
                            end
                        end
                        tahoe_pkg::CMD_START:
                        begin
                            cwnd_next = init_win_reg;
                            ssth_next = init_thr_reg;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    st_next = ST_ADD;
            end
            ST_ADD:
            begin
                cwnd_next = add_sum;
                st_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.window        = cwnd_reg;
                    out_data_next.threshold     = ssth_reg;
                    out_data_next.retransmit    = rtx_reg;
                    out_data_next.try_send      = try_reg;
                    out_data_next.after_timeout = rto_reg;
                    st_next                     = ST_IDLE;
                end
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            cwnd_reg      <= tahoe_pkg::INIT_WIN_RST;
            ssth_reg      <= tahoe_pkg::INIT_THR_RST;
            rto_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cwnd_reg      <= cwnd_next;
            ssth_reg      <= ssth_next;
            rto_reg       <= rto_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rtx_reg      <= rtx_next;
        try_reg      <= try_next;
        out_data_reg <= out_data_next;
    end

    assign out_word.valid = out_valid_reg;
    assign out_word.data  = out_data_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (st_reg == ST_DIV))
        else $error("divider running outside the divide step");

    a_rto_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rto_reg |=> rto_reg)
        else $error("after-timeout mark cleared");

    a_avoid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_ADD) |=> (cwnd_reg > $past(cwnd_reg)) || (cwnd_reg == {W{1'b1}}))
        else $error("avoidance step did not grow the window");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((st_reg == ST_FIN) && slot_free) |=> out_valid_reg && (st_reg == ST_IDLE))
        else $error("result not written on leaving the final step");

endmodule

### src/tahoe_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tahoe_pkg for the control/status structs.
module tahoe_div #(
    parameter int WIDTH = tahoe_pkg::WIN_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tahoe_pkg::div_ctrl_t  ctrl,
    input  logic [WIDTH-1:0]      dividend,
    input  logic [WIDTH-1:0]      divisor,
    output tahoe_pkg::div_stat_t  stat,
    output logic [WIDTH-1:0]      quotient
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   trial;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        trial     = rem_shift - {1'b0, dsr_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (ctrl.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it does not borrow
            if (!trial[WIDTH])
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### tb/tb_top.sv
// Self-checking bench for tcp_tahoe_congestion_window: random and directed event words,
// a cwnd/ssthresh tracker in a scoreboard class, random stalls on both channels.
// Depends on tahoe_pkg, tahoe_in_if, tahoe_out_if and the block itself.
module tb_top;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int DRAIN_CYCLES = 40;     // longer than the divide path
    localparam int LONG_HOLD    = 300;    // receiver hold-off used to back the block up
    localparam int PHASE_WORDS  = 180;

    // Tracks cwnd, ssthresh and the timeout mark from accepted event words, and holds
    // the results still owed by the block, oldest first.
    class tahoe_window_board;
        tahoe_pkg::out_word_t pending_windows[$];
        logic [15:0] mss;
        logic [31:0] init_win;
        logic [31:0] init_thr;
        logic [7:0]  dup_thr;
        logic [31:0] cwnd;
        logic [31:0] ssthresh;
        logic        rto_mark;
        int          errors;
        int          checked;

        function new();
            mss      = tahoe_pkg::MSS_RST;
            init_win = tahoe_pkg::INIT_WIN_RST;
            init_thr = tahoe_pkg::INIT_THR_RST;
            dup_thr  = tahoe_pkg::DUP_THR_RST;
            cwnd     = tahoe_pkg::INIT_WIN_RST;
            ssthresh = tahoe_pkg::INIT_THR_RST;
            rto_mark = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void write_reg(logic [tahoe_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                tahoe_pkg::CFG_MSS:      mss      = value[15:0];
                tahoe_pkg::CFG_INIT_WIN: init_win = value;
                tahoe_pkg::CFG_INIT_THR: init_thr = value;
                tahoe_pkg::CFG_DUP_THR:  dup_thr  = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] clamped_sum(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        // loss: ssthresh to half the flight estimate (floor 2*MSS), cwnd to one MSS
        function void collapse(logic [tahoe_pkg::PEER_W-1:0] peer);
            logic [31:0] flight;
            logic [31:0] half;
            logic [31:0] floor2;
            flight   = (cwnd < {2'b00, peer}) ? cwnd : {2'b00, peer};
            half     = flight >> 1;
            floor2   = {15'd0, mss, 1'b0};
            ssthresh = (half > floor2) ? half : floor2;
            cwnd     = {16'd0, mss};
        endfunction

        function void take_event(tahoe_pkg::in_word_t w);
            tahoe_pkg::out_word_t res;
            logic [63:0] sq;
            logic [63:0] q;
            logic [31:0] incr;
            res = '0;
            res.retransmit = tahoe_pkg::RTX_NONE;
            case (w.command)
                tahoe_pkg::CMD_NEW_ACK:
                begin
                    if (cwnd < ssthresh)
                        cwnd = clamped_sum(cwnd, {16'd0, mss});
                    else
                    begin
                        sq = {48'd0, mss} * {48'd0, mss};
                        q  = sq / ((cwnd == 32'd0) ? 64'd1 : {32'd0, cwnd});
                        incr = (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                        if (incr == 32'd0)
                            incr = 32'd1;
                        cwnd = clamped_sum(cwnd, incr);
                    end
                    res.try_send = 1'b1;
                end
                tahoe_pkg::CMD_DUP_ACK:
                begin
                    if (w.dup_count == dup_thr)
                    begin
                        collapse(w.peer_window);
                        res.retransmit = tahoe_pkg::RTX_FAST;
                    end
                end
                tahoe_pkg::CMD_TIMEOUT:
                begin
                    if (!w.aborted)
                    begin
                        collapse(w.peer_window);
                        rto_mark = 1'b1;
                        res.retransmit = tahoe_pkg::RTX_TIMEOUT;
                    end
                end
                default:
                begin
                    cwnd     = init_win;
                    ssthresh = init_thr;
                end
            endcase
            res.window        = cwnd;
            res.threshold     = ssthresh;
            res.after_timeout = rto_mark;
            pending_windows.push_back(res);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_window(tahoe_pkg::out_word_t got);
            tahoe_pkg::out_word_t want;
            checked++;
            if (pending_windows.size() == 0)
            begin
                flag_mismatch($sformatf("result word with nothing pending (window %0d)",
                                        got.window));
                return;
            end
            want = pending_windows.pop_front();
            if (got.window !== want.window)
                flag_mismatch($sformatf("word %0d window %0d, want %0d",
                                        checked, got.window, want.window));
            if (got.threshold !== want.threshold)
                flag_mismatch($sformatf("word %0d threshold %0d, want %0d",
                                        checked, got.threshold, want.threshold));
            if (got.retransmit !== want.retransmit)
                flag_mismatch($sformatf("word %0d retransmit %0d, want %0d",
                                        checked, got.retransmit, want.retransmit));
            if (got.try_send !== want.try_send)
                flag_mismatch($sformatf("word %0d try_send %0b, want %0b",
                                        checked, got.try_send, want.try_send));
            if (got.after_timeout !== want.after_timeout)
                flag_mismatch($sformatf("word %0d after_timeout %0b, want %0b",
                                        checked, got.after_timeout, want.after_timeout));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [tahoe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tahoe_pkg::CFG_DATA_W-1:0] cfg_data;

    tahoe_in_if  in_if ();
    tahoe_out_if out_if ();

    tahoe_window_board sb;

    int  burst_left = 0;       // words still to send back to back
    bit  first_hold_done = 0;
    bit  second_hold_done = 0;

    tcp_tahoe_congestion_window DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_if),
        .out_word  (out_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: generous bound over the slowest legal run.
    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Mostly no gap or a short one, now and then a long one; bursts with no gap at all.
    function automatic int sender_gap();
        int pick;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            burst_left = $urandom_range(30, 80);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic tahoe_pkg::in_word_t make_word(
        logic [tahoe_pkg::CMD_W-1:0] cmd, logic [tahoe_pkg::PEER_W-1:0] peer,
        logic [tahoe_pkg::DUP_W-1:0] dups, logic ab);
        tahoe_pkg::in_word_t w;
        w.command     = cmd;
        w.peer_window = peer;
        w.dup_count   = dups;
        w.aborted     = ab;
        return w;
    endfunction

    // Mix leaning on new-data ACKs so cwnd walks through slow start into avoidance;
    // half of the duplicate ACKs hit the configured count so fast retransmit is frequent.
    function automatic tahoe_pkg::in_word_t random_word();
        tahoe_pkg::in_word_t w;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            w.command = tahoe_pkg::CMD_NEW_ACK;
        else if (pick < 72)
            w.command = tahoe_pkg::CMD_DUP_ACK;
        else if (pick < 86)
            w.command = tahoe_pkg::CMD_TIMEOUT;
        else
            w.command = tahoe_pkg::CMD_START;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            w.peer_window = tahoe_pkg::PEER_W'($urandom());
        else if (pick < 70)
            w.peer_window = tahoe_pkg::PEER_W'($urandom_range(0, 1 << 18));
        else if (pick < 85)
            w.peer_window = '0;
        else
            w.peer_window = '1;
        if ($urandom_range(0, 1) == 1)
            w.dup_count = sb.dup_thr;
        else
            w.dup_count = tahoe_pkg::DUP_W'($urandom());
        w.aborted = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Entered and left at a falling edge; the word is noted once the handshake completes.
    task automatic send_word(input tahoe_pkg::in_word_t w);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.take_event(w);
        @(negedge clk);
    endtask

    // Waits for every owed result, then lets the divider path run out.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending_windows.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes all four registers on consecutive edges; block must be idle.
    task automatic program_regs(input logic [31:0] mss_v, input logic [31:0] win_v,
                                input logic [31:0] thr_v, input logic [31:0] dup_v);
        cfg_we    <= 1'b1;
        cfg_index <= tahoe_pkg::CFG_MSS;
        cfg_data  <= mss_v;
        sb.write_reg(tahoe_pkg::CFG_MSS, mss_v);
        @(negedge clk);
        cfg_index <= tahoe_pkg::CFG_INIT_WIN;
        cfg_data  <= win_v;
        sb.write_reg(tahoe_pkg::CFG_INIT_WIN, win_v);
        @(negedge clk);
        cfg_index <= tahoe_pkg::CFG_INIT_THR;
        cfg_data  <= thr_v;
        sb.write_reg(tahoe_pkg::CFG_INIT_THR, thr_v);
        @(negedge clk);
        cfg_index <= tahoe_pkg::CFG_DUP_THR;
        cfg_data  <= dup_v;
        sb.write_reg(tahoe_pkg::CFG_DUP_THR, dup_v);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // A start word first so the new settings take effect, then random traffic.
    task automatic run_phase(input int n);
        send_word(make_word(tahoe_pkg::CMD_START, tahoe_pkg::PEER_W'($urandom()), '0, 1'b0));
        repeat (n) send_word(random_word());
        wait_drained();
    endtask

    // Smaller random window values now and then, so slow start gets exercised.
    function automatic logic [31:0] random_window();
        if ($urandom_range(0, 1) == 1)
            return $urandom();
        return $urandom_range(1, 200000);
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random ready with two long hold-offs
    // ------------------------------------------------------------------
    initial
    begin
        bit rdy;
        int n;
        int pick;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            pick = $urandom_range(0, 99);
            if ((!first_hold_done && sb.checked >= 350) ||
                (!second_hold_done && sb.checked >= 1100))
            begin
                // sender keeps offering while the result side is shut, so the block
                // fills and must hold its input ready low
                if (!first_hold_done)
                    first_hold_done = 1;
                else
                    second_hold_done = 1;
                rdy = 1'b0;
                n   = LONG_HOLD;
            end
            else if (pick < 5)
            begin
                rdy = 1'b1;
                n   = $urandom_range(50, 150);
            end
            else if (pick < 55)
            begin
                rdy = 1'b1;
                n   = $urandom_range(1, 8);
            end
            else if (pick < 92)
            begin
                rdy = 1'b0;
                n   = $urandom_range(1, 3);
            end
            else
            begin
                rdy = 1'b0;
                n   = $urandom_range(10, 60);
            end
            out_if.ready <= rdy;
            repeat (n - 1) @(negedge clk);
        end
    end

    // Result monitor: values read at the rising edge are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_window(out_if.data);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = tahoe_pkg::CFG_MSS;
        cfg_data    = '0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words at reset settings: mss 536, cwnd 536, ssthresh 65535, dup count 3.
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, '0, '0, 1'b0));        // slow start
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, '1, '1, 1'b1));        // abort flag ignored
        send_word(make_word(tahoe_pkg::CMD_DUP_ACK, '1, 8'd3, 1'b0));      // fast retransmit
        send_word(make_word(tahoe_pkg::CMD_DUP_ACK, '1, 8'd2, 1'b0));      // count off by one
        send_word(make_word(tahoe_pkg::CMD_DUP_ACK, '0, 8'd255, 1'b1));
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, 30'd1000, '0, 1'b0));  // slow start
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, 30'd1000, '0, 1'b0));  // divide path
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, 30'd1000, '0, 1'b0));
        send_word(make_word(tahoe_pkg::CMD_TIMEOUT, '1, '0, 1'b1));        // aborted
        send_word(make_word(tahoe_pkg::CMD_TIMEOUT, '0, '0, 1'b0));        // floor 2*mss
        send_word(make_word(tahoe_pkg::CMD_START, '1, '1, 1'b1));          // mark survives
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, '1, '0, 1'b0));
        send_word(make_word(tahoe_pkg::CMD_TIMEOUT, '1, '1, 1'b0));        // cwnd limits
        send_word(make_word(tahoe_pkg::CMD_DUP_ACK, '0, 8'd0, 1'b0));
        send_word(make_word(tahoe_pkg::CMD_START, '0, '0, 1'b0));
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, 30'h2AAA_AAAA, 8'hAA, 1'b0));
        send_word(make_word(tahoe_pkg::CMD_DUP_ACK, 30'h1555_5555, 8'd3, 1'b1)); // cwnd limits
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, 30'h1555_5555, 8'h55, 1'b1));
        send_word(make_word(tahoe_pkg::CMD_TIMEOUT, 30'd100, 8'd3, 1'b0));
        send_word(make_word(tahoe_pkg::CMD_NEW_ACK, '0, '0, 1'b0));
        run_phase(PHASE_WORDS);

        // lowest legal settings
        program_regs(32'd1, 32'd1, 32'd1, 32'd1);
        run_phase(PHASE_WORDS);

        // highest legal settings: cwnd starts at the ceiling, increments clamp
        program_regs(32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255);
        run_phase(PHASE_WORDS);

        // slow start step that overflows and clamps
        program_regs(32'd65535, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'd3);
        run_phase(PHASE_WORDS);

        // out-of-range zeros (upper data bits set, masked off): zero cwnd in avoidance
        program_regs(32'hFFFF_0000, 32'd0, 32'd0, 32'hFFFF_FF00);
        run_phase(PHASE_WORDS);

        // small cwnd against large mss: big avoidance increment
        program_regs(32'd65535, 32'd1, 32'd2, 32'd1);
        run_phase(PHASE_WORDS);

        // random settings: mss and dup count data fully random, windows from random_window
        repeat (3)
        begin
            program_regs($urandom(), random_window(), random_window(), $urandom());
            run_phase(PHASE_WORDS);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### tcp_tahoe_congestion_window.f
src/tahoe_pkg.sv
src/tahoe_in_if.sv
src/tahoe_out_if.sv
src/tahoe_div.sv
src/tcp_tahoe_congestion_window.sv
tb/tb_top.sv
